FILE: hw/rtl/transformed_vertex_bounding_box_unit_macros.svh
// Assertion macros for the bounding box unit
`ifndef TRANSFORMED_VERTEX_BOUNDING_BOX_UNIT_MACROS_SVH
`define TRANSFORMED_VERTEX_BOUNDING_BOX_UNIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define TVB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvb check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define TVB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvb check failed");

`endif

FILE: hw/rtl/tvbb_pkg.sv
// ----------------------------------------------------------------------------
// tvbb_pkg
// Types, constants and helper functions for the bounding box unit.
// ----------------------------------------------------------------------------
package tvbb_pkg;

    localparam int DEFAULT_COORD_WIDTH = 32;
    localparam int FIELD_W = 32;
    localparam int QUAT_W = 16;
    localparam int MAT_W = 18;

    typedef enum logic [1:0] {
        OP_NODE   = 2'd0,
        OP_VERTEX = 2'd1,
        OP_FINISH = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAT,
        ST_SCALE,
        ST_ROT,
        ST_WIDEN,
        ST_OUT
    } state_t;

    // command bundle from controller to datapath
    typedef struct packed {
        logic       load_node;
        logic       mat_step;
        logic       scale_step;
        logic       rot_step;
        logic       widen_geo;
        logic       finish;
        logic [3:0] step;
    } cmd_t;

    // saturate a 64-bit signed value to a signed width w (16..32), 32-bit result
    function automatic logic signed [31:0] sat_w(input logic signed [63:0] v, input int w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        begin
            hi = (64'sd1 <<< (w - 1)) - 64'sd1;
            lo = -hi - 64'sd1;
            if (v > hi)
                sat_w = hi[31:0];
            else if (v < lo)
                sat_w = lo[31:0];
            else
                sat_w = v[31:0];
        end
    endfunction

endpackage

FILE: hw/rtl/tvbb_ctrl.sv
// ----------------------------------------------------------------------------
// tvbb_ctrl
// Sequencer: steps the matrix build, then scale and rotate on the shared multiplier.
// ----------------------------------------------------------------------------
module tvbb_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    output logic               out_valid,
    input  logic               out_ready,
    output tvbb_pkg::cmd_t     cmd
);
    import tvbb_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    priority case (op_t'(operation))
                        OP_NODE:   state_next = ST_MAT;
                        OP_VERTEX: state_next = ST_SCALE;
                        OP_FINISH: state_next = ST_OUT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MAT:
            begin
                // nine matrix entries, one per cycle
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd8)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCALE:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd2)
                begin
                    state_next = ST_ROT;
                    step_next  = '0;
                end
            end
            ST_ROT:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd8)
                begin
                    state_next = ST_WIDEN;
                end
            end
            ST_WIDEN:
                state_next = ST_IDLE;
            ST_OUT:
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        out_valid      = (state_reg == ST_OUT);
        cmd            = '0;
        cmd.step       = step_reg;
        cmd.load_node  = in_ready && in_valid && (operation == OP_NODE);
        cmd.mat_step   = (state_reg == ST_MAT);
        cmd.scale_step = (state_reg == ST_SCALE);
        cmd.rot_step   = (state_reg == ST_ROT);
        cmd.widen_geo  = (state_reg == ST_WIDEN);
        cmd.finish     = out_valid && out_ready;
    end

endmodule

FILE: hw/rtl/tvbb_datapath.sv
// ----------------------------------------------------------------------------
// tvbb_datapath
// Transform registers, one shared multiplier, box registers.
// ----------------------------------------------------------------------------
module tvbb_datapath
#(
    parameter int COORD_WIDTH = tvbb_pkg::DEFAULT_COORD_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tvbb_pkg::cmd_t      cmd,
    input  logic                in_accept,
    input  logic [1:0]          operation,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    input  logic signed [31:0]  scale_x,
    input  logic signed [31:0]  scale_y,
    input  logic signed [31:0]  scale_z,
    input  logic signed [15:0]  quat_w,
    input  logic signed [15:0]  quat_x,
    input  logic signed [15:0]  quat_y,
    input  logic signed [15:0]  quat_z,
    output logic signed [31:0]  box_min_x,
    output logic signed [31:0]  box_min_y,
    output logic signed [31:0]  box_min_z,
    output logic signed [31:0]  box_max_x,
    output logic signed [31:0]  box_max_y,
    output logic signed [31:0]  box_max_z,
    output logic                box_valid,
    output logic                from_geometry
);
    import tvbb_pkg::*;

    localparam int EW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);

    logic signed [MAT_W-1:0]   mat_reg [9];
    logic signed [31:0]        pos_reg [3];
    logic signed [31:0]        scl_reg [3];
    logic signed [31:0]        vin_reg [3];
    logic signed [31:0]        svec_reg [3];
    logic signed [31:0]        world_reg [3];
    logic signed [QUAT_W-1:0]  q_reg [4];
    logic signed [31:0]        gmin_reg [3], gmax_reg [3], fmin_reg [3], fmax_reg [3];
    logic                      gseen_reg, fseen_reg;
    logic signed [51:0]        acc_reg;

    logic signed [31:0] pin [3];
    logic signed [31:0] sin_v [3];
    logic signed [31:0] vin [3];
    assign pin[0] = sat_w(64'(coord_x), EW);
    assign pin[1] = sat_w(64'(coord_y), EW);
    assign pin[2] = sat_w(64'(coord_z), EW);
    assign sin_v[0] = sat_w(64'(scale_x), EW);
    assign sin_v[1] = sat_w(64'(scale_y), EW);
    assign sin_v[2] = sat_w(64'(scale_z), EW);
    assign vin = pin;

    // matrix entry: two quaternion products per entry, combined below
    logic [1:0]          qa0, qb0, qa1, qb1;
    logic                msub, mdiag;
    logic signed [31:0]  qp0, qp1;
    logic signed [33:0]  qsum, qsum2;
    logic signed [33:0]  mraw;
    logic signed [33:0]  mrnd;

    // quaternion index: 0 w, 1 x, 2 y, 3 z
    always_comb
    begin
        qa0 = 2'd2; qb0 = 2'd2; qa1 = 2'd3; qb1 = 2'd3; msub = 1'b0; mdiag = 1'b1;
        unique case (cmd.step)
            4'd0: begin qa0 = 2'd2; qb0 = 2'd2; qa1 = 2'd3; qb1 = 2'd3; mdiag = 1'b1; end
            4'd1: begin qa0 = 2'd1; qb0 = 2'd2; qa1 = 2'd0; qb1 = 2'd3; msub = 1'b1; mdiag = 1'b0; end
            4'd2: begin qa0 = 2'd1; qb0 = 2'd3; qa1 = 2'd0; qb1 = 2'd2; mdiag = 1'b0; end
            4'd3: begin qa0 = 2'd1; qb0 = 2'd2; qa1 = 2'd0; qb1 = 2'd3; mdiag = 1'b0; end
            4'd4: begin qa0 = 2'd1; qb0 = 2'd1; qa1 = 2'd3; qb1 = 2'd3; mdiag = 1'b1; end
            4'd5: begin qa0 = 2'd2; qb0 = 2'd3; qa1 = 2'd0; qb1 = 2'd1; msub = 1'b1; mdiag = 1'b0; end
            4'd6: begin qa0 = 2'd1; qb0 = 2'd3; qa1 = 2'd0; qb1 = 2'd2; msub = 1'b1; mdiag = 1'b0; end
            4'd7: begin qa0 = 2'd2; qb0 = 2'd3; qa1 = 2'd0; qb1 = 2'd1; mdiag = 1'b0; end
            default: begin qa0 = 2'd1; qb0 = 2'd1; qa1 = 2'd2; qb1 = 2'd2; mdiag = 1'b1; end
        endcase
    end

    assign qp0  = q_reg[qa0] * q_reg[qb0];
    assign qp1  = q_reg[qa1] * q_reg[qb1];
    assign qsum = msub ? (34'(qp0) - 34'(qp1)) : (34'(qp0) + 34'(qp1));
    assign qsum2 = qsum <<< 1;
    assign mraw = mdiag ? ((34'sd1 <<< 28) - qsum2) : qsum2;
    assign mrnd = (mraw + 34'sd8192) >>> 14;

    logic signed [MAT_W-1:0] mat_entry;
    always_comb
    begin
        if (mrnd > 34'sd131071)
            mat_entry = 18'sd131071;
        else if (mrnd < -34'sd131072)
            mat_entry = -18'sd131072;
        else
            mat_entry = mrnd[MAT_W-1:0];
    end

    // shared 32x32 multiplier for scale and rotate
    logic signed [31:0] ma, mb;
    logic signed [63:0] mprod;
    logic [1:0]         ri, ci;
    assign ri = (cmd.step > 4'd5) ? 2'd2 : ((cmd.step > 4'd2) ? 2'd1 : 2'd0);
    assign ci = 2'(cmd.step - 4'(ri) * 4'd3);
    always_comb
    begin
        if (cmd.scale_step)
        begin
            ma = vin_reg[cmd.step[1:0]];
            mb = scl_reg[cmd.step[1:0]];
        end
        else
        begin
            ma = 32'(mat_reg[cmd.step]);
            mb = svec_reg[ci];
        end
    end
    assign mprod = ma * mb;

    logic signed [63:0] srnd;
    assign srnd = (mprod + 64'sd32768) >>> 16;
    // three products of up to 2^48 each fit in 52 bits
    logic signed [51:0] acc_sum;
    assign acc_sum = ((ci == 2'd0) ? 52'sd0 : acc_reg) + $signed(mprod[51:0]);
    logic signed [63:0] wsum;
    assign wsum = 64'((acc_sum + 52'sd8192) >>> 14) + 64'(pos_reg[ri]);

    always_ff @(posedge clk)
    begin
        if (cmd.load_node)
        begin
            q_reg[0] <= quat_w; q_reg[1] <= quat_x; q_reg[2] <= quat_y; q_reg[3] <= quat_z;
        end
        if (in_accept && operation == OP_VERTEX)
        begin
            for (int i = 0; i < 3; i++) vin_reg[i] <= vin[i];
        end
        if (cmd.scale_step)
            svec_reg[cmd.step[1:0]] <= sat_w(srnd, EW);
        if (cmd.rot_step)
        begin
            acc_reg <= acc_sum;
            if (ci == 2'd2)
                world_reg[ri] <= sat_w(wsum, EW);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                mat_reg[i] <= (i % 4 == 0) ? 18'sd16384 : 18'sd0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0; scl_reg[i] <= 32'sd65536;
                gmin_reg[i] <= '0; gmax_reg[i] <= '0;
                fmin_reg[i] <= '0; fmax_reg[i] <= '0;
            end
            gseen_reg <= 1'b0;
            fseen_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_node)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pos_reg[i] <= pin[i];
                    scl_reg[i] <= sin_v[i];
                    if (!fseen_reg || pin[i] < fmin_reg[i]) fmin_reg[i] <= pin[i];
                    if (!fseen_reg || pin[i] > fmax_reg[i]) fmax_reg[i] <= pin[i];
                end
                fseen_reg <= 1'b1;
            end
            if (cmd.mat_step)
                mat_reg[cmd.step] <= mat_entry;
            if (cmd.widen_geo)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (!gseen_reg || world_reg[i] < gmin_reg[i]) gmin_reg[i] <= world_reg[i];
                    if (!gseen_reg || world_reg[i] > gmax_reg[i]) gmax_reg[i] <= world_reg[i];
                end
                gseen_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    gmin_reg[i] <= '0; gmax_reg[i] <= '0;
                    fmin_reg[i] <= '0; fmax_reg[i] <= '0;
                end
                gseen_reg <= 1'b0;
                fseen_reg <= 1'b0;
            end
        end
    end

    // cleared boxes hold zero, so an empty finish reads zero
    assign box_min_x     = gseen_reg ? gmin_reg[0] : fmin_reg[0];
    assign box_min_y     = gseen_reg ? gmin_reg[1] : fmin_reg[1];
    assign box_min_z     = gseen_reg ? gmin_reg[2] : fmin_reg[2];
    assign box_max_x     = gseen_reg ? gmax_reg[0] : fmax_reg[0];
    assign box_max_y     = gseen_reg ? gmax_reg[1] : fmax_reg[1];
    assign box_max_z     = gseen_reg ? gmax_reg[2] : fmax_reg[2];
    assign box_valid     = gseen_reg | fseen_reg;
    assign from_geometry = gseen_reg;

endmodule

FILE: hw/rtl/transformed_vertex_bounding_box_unit.sv
// ----------------------------------------------------------------------------
// transformed_vertex_bounding_box_unit
// World-space axis-aligned box over a stream of nodes and vertices.
// ----------------------------------------------------------------------------
// channel   handshake              payload
// input     in_valid / in_ready    operation, coord_*, scale_*, quat_*
// output    out_valid / out_ready  box_min_*, box_max_*, box_valid, from_geometry
//
// Node: nine matrix entries on the quaternion product pair.
// Vertex: 3 scale + 9 rotate products on one 32x32 multiplier, widen.
// Finish: box held on the output until taken; reserved op: accepted and ignored.
// Reset restores identity transform and clears both boxes at once.
// ----------------------------------------------------------------------------
`include "transformed_vertex_bounding_box_unit_macros.svh"

module transformed_vertex_bounding_box_unit
#(
    parameter int COORD_WIDTH = tvbb_pkg::DEFAULT_COORD_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic signed [31:0] scale_x,
    input  logic signed [31:0] scale_y,
    input  logic signed [31:0] scale_z,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] box_min_x,
    output logic signed [31:0] box_min_y,
    output logic signed [31:0] box_min_z,
    output logic signed [31:0] box_max_x,
    output logic signed [31:0] box_max_y,
    output logic signed [31:0] box_max_z,
    output logic               box_valid,
    output logic               from_geometry
);
    import tvbb_pkg::*;

    cmd_t cmd;

    tvbb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    tvbb_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_accept     (in_valid && in_ready),
        .operation     (operation),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .scale_x       (scale_x),
        .scale_y       (scale_y),
        .scale_z       (scale_z),
        .quat_w        (quat_w),
        .quat_x        (quat_x),
        .quat_y        (quat_y),
        .quat_z        (quat_z),
        .box_min_x     (box_min_x),
        .box_min_y     (box_min_y),
        .box_min_z     (box_min_z),
        .box_max_x     (box_max_x),
        .box_max_y     (box_max_y),
        .box_max_z     (box_max_z),
        .box_valid     (box_valid),
        .from_geometry (from_geometry)
    );

    `TVB_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
    `TVB_ASSERT_NEXT(a_finish_to_out, in_valid && in_ready && operation == OP_FINISH, out_valid)
    `TVB_ASSERT_NEXT(a_clear_after_out, out_valid && out_ready, !box_valid)
    `TVB_ASSERT_IMP(a_geo_implies_valid, from_geometry, box_valid)

endmodule

FILE: tb/sv/tb_transformed_vertex_bounding_box_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_transformed_vertex_bounding_box_unit
// Self-checking bench: streams node, vertex and finish requests with random
// gaps and stalls, predicts each box in fixed point and compares every field.
// ----------------------------------------------------------------------------
module tb_transformed_vertex_bounding_box_unit;
    import tvbb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [31:0] mn [3];
        logic signed [31:0] mx [3];
        logic               valid;
        logic               geo;
    } box_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] operation;
    logic signed [31:0] coord_x, coord_y, coord_z;
    logic signed [31:0] scale_x, scale_y, scale_z;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] box_min_x, box_min_y, box_min_z;
    logic signed [31:0] box_max_x, box_max_y, box_max_z;
    logic box_valid, from_geometry;

    transformed_vertex_bounding_box_unit u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .scale_x(scale_x), .scale_y(scale_y),
        .scale_z(scale_z), .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y),
        .quat_z(quat_z), .out_valid(out_valid), .out_ready(out_ready),
        .box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
        .box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
        .box_valid(box_valid), .from_geometry(from_geometry)
    );

    // predictor state
    longint rot_mat [9];
    longint node_pos [3];
    longint node_scl [3];
    longint geo_mn [3], geo_mx [3], fb_mn [3], fb_mx [3];
    bit geo_seen, fb_seen;

    box_t expected_boxes [$];
    int error_count;
    int idle_cycles;
    bit long_hold;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat32(longint v);
        return clamp(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint round_entry(longint q28);
        return clamp((q28 + 64'sd8192) >>> 14, -64'sd131072, 64'sd131071);
    endfunction

    function automatic void clear_boxes();
        for (int i = 0; i < 3; i++)
        begin
            geo_mn[i] = 0; geo_mx[i] = 0; fb_mn[i] = 0; fb_mx[i] = 0;
        end
        geo_seen = 0;
        fb_seen = 0;
    endfunction

    function automatic void reset_transform();
        for (int i = 0; i < 9; i++)
            rot_mat[i] = (i % 4 == 0) ? 16384 : 0;
        for (int i = 0; i < 3; i++)
        begin
            node_pos[i] = 0;
            node_scl[i] = 65536;
        end
        clear_boxes();
    endfunction

    function automatic void widen_box(ref longint mn [3], ref longint mx [3], ref bit seen,
                                      input longint p [3]);
        for (int i = 0; i < 3; i++)
        begin
            if (!seen || p[i] < mn[i]) mn[i] = p[i];
            if (!seen || p[i] > mx[i]) mx[i] = p[i];
        end
        seen = 1;
    endfunction

    function automatic void predict_box(op_t op, longint c [3], longint s [3], longint qw,
                                        longint qx, longint qy, longint qz);
        longint one;
        longint scaled [3];
        longint world [3];
        longint acc;
        box_t b;
        one = 64'sd1 << 28;
        case (op)
            OP_NODE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    node_pos[i] = c[i];
                    node_scl[i] = s[i];
                end
                rot_mat[0] = round_entry(one - 2 * (qy * qy + qz * qz));
                rot_mat[1] = round_entry(2 * (qx * qy - qw * qz));
                rot_mat[2] = round_entry(2 * (qx * qz + qw * qy));
                rot_mat[3] = round_entry(2 * (qx * qy + qw * qz));
                rot_mat[4] = round_entry(one - 2 * (qx * qx + qz * qz));
                rot_mat[5] = round_entry(2 * (qy * qz - qw * qx));
                rot_mat[6] = round_entry(2 * (qx * qz - qw * qy));
                rot_mat[7] = round_entry(2 * (qy * qz + qw * qx));
                rot_mat[8] = round_entry(one - 2 * (qx * qx + qy * qy));
                widen_box(fb_mn, fb_mx, fb_seen, node_pos);
            end
            OP_VERTEX:
            begin
                for (int i = 0; i < 3; i++)
                    scaled[i] = sat32((c[i] * node_scl[i] + 64'sd32768) >>> 16);
                for (int i = 0; i < 3; i++)
                begin
                    acc = rot_mat[3*i] * scaled[0] + rot_mat[3*i+1] * scaled[1]
                        + rot_mat[3*i+2] * scaled[2];
                    world[i] = sat32(((acc + 64'sd8192) >>> 14) + node_pos[i]);
                end
                widen_box(geo_mn, geo_mx, geo_seen, world);
            end
            OP_FINISH:
            begin
                b.valid = geo_seen || fb_seen;
                b.geo = geo_seen;
                for (int i = 0; i < 3; i++)
                begin
                    b.mn[i] = !b.valid ? 0 : (geo_seen ? geo_mn[i] : fb_mn[i]);
                    b.mx[i] = !b.valid ? 0 : (geo_seen ? geo_mx[i] : fb_mx[i]);
                end
                expected_boxes.push_back(b);
                clear_boxes();
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_request(op_t op, logic signed [31:0] cx, logic signed [31:0] cy,
                                logic signed [31:0] cz, logic signed [31:0] sx,
                                logic signed [31:0] sy, logic signed [31:0] sz,
                                logic signed [15:0] qw, logic signed [15:0] qx,
                                logic signed [15:0] qy, logic signed [15:0] qz);
        longint c [3];
        longint s [3];
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        // drop valid only when idling; back to back keeps it high
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        coord_x <= cx; coord_y <= cy; coord_z <= cz;
        scale_x <= sx; scale_y <= sy; scale_z <= sz;
        quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
        do @(posedge clk); while (!in_ready);
        c[0] = cx; c[1] = cy; c[2] = cz;
        s[0] = sx; s[1] = sy; s[2] = sz;
        predict_box(op, c, s, qw, qx, qy, qz);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_scale();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh00010000;
            default: return $signed($urandom_range(0, 32'h0007ffff)) - 32'sh0003ffff;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_quat();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endfunction

    task automatic send_node_rand();
        send_request(OP_NODE, rand_coord(), rand_coord(), rand_coord(), rand_scale(),
                     rand_scale(), rand_scale(), rand_quat(), rand_quat(), rand_quat(),
                     rand_quat());
    endtask

    task automatic send_vertex_rand();
        send_request(OP_VERTEX, rand_coord(), rand_coord(), rand_coord(), $urandom,
                     $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
    endtask

    task automatic send_finish();
        send_request(OP_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
    endtask

    task automatic test_directed();
        // empty finish, vertex before any node, reserved op
        send_finish();
        send_request(OP_VERTEX, 32'sh00010000, -32'sh00020000, 32'sh7fffffff, 0, 0, 0,
                     0, 0, 0, 0);
        send_request(OP_RSVD, 32'sh80000000, 1, 2, 3, 4, 5, 6, 7, 8, 9);
        send_finish();
        // identity node, then nodes only: fallback box
        send_request(OP_NODE, 32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff,
                     32'sh80000000, 32'sh00010000, 16384, 0, 0, 0);
        send_request(OP_NODE, -32'sh00050000, 32'sh00030000, -1, 32'sh00010000,
                     32'sh00010000, 32'sh00010000, 0, 16384, 0, 0);
        send_finish();
        // saturating scale and rotation with the transform kept over finish
        send_request(OP_VERTEX, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 0,
                     0, 0, 0, 0);
        send_request(OP_VERTEX, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 0, 0, 0, 0);
        send_finish();
        // quaternion extremes, including non-unit and full-range bit patterns
        send_request(OP_NODE, 0, 0, 0, 32'sh00010000, 32'sh00010000, 32'sh00010000,
                     -16384, 16384, -16384, 16384);
        send_request(OP_VERTEX, 32'sh00010000, 32'sh00010000, 32'sh00010000, 0, 0, 0,
                     0, 0, 0, 0);
        send_request(OP_NODE, 32'sh00001000, 0, 0, 32'sh00020000, -32'sh00010000,
                     32'sh00008000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_request(OP_VERTEX, -32'sh00030000, 32'sh00001234, 32'sh7fffffff, 0, 0, 0,
                     0, 0, 0, 0);
        send_request(OP_VERTEX, 32'sh00100000, -32'sh00100000, -1, 0, 0, 0, 0, 0, 0, 0);
        send_finish();
        send_finish();
    endtask

    task automatic test_random_scenes();
        int sent;
        int nv;
        sent = 0;
        while (sent < 880)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: random op including reserved
                send_request(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
                sent++;
            end
            else
            begin
                repeat ($urandom_range(0, 3))
                begin
                    send_node_rand();
                    sent++;
                    nv = $urandom_range(0, 6);
                    repeat (nv)
                    begin
                        send_vertex_rand();
                        sent++;
                    end
                end
                send_finish();
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        long_hold = 1'b1;
        repeat (10)
        begin
            send_finish();
        end
        long_hold = 1'b0;
    endtask

    // receiver: random stall per result, long hold-off when requested
    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                for (hold = 0; hold < 300; hold++)
                    @(posedge clk);
            end
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        box_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_boxes.size() == 0)
            begin
                $display("unexpected box result");
                error_count++;
            end
            else
            begin
                want = expected_boxes.pop_front();
                if (box_min_x !== want.mn[0]) report_mismatch("box_min_x", box_min_x, want.mn[0]);
                if (box_min_y !== want.mn[1]) report_mismatch("box_min_y", box_min_y, want.mn[1]);
                if (box_min_z !== want.mn[2]) report_mismatch("box_min_z", box_min_z, want.mn[2]);
                if (box_max_x !== want.mx[0]) report_mismatch("box_max_x", box_max_x, want.mx[0]);
                if (box_max_y !== want.mx[1]) report_mismatch("box_max_y", box_max_y, want.mx[1]);
                if (box_max_z !== want.mx[2]) report_mismatch("box_max_z", box_max_z, want.mx[2]);
                if (box_valid !== want.valid) report_mismatch("box_valid", box_valid, want.valid);
                if (from_geometry !== want.geo)
                    report_mismatch("from_geometry", from_geometry, want.geo);
            end
        end
    end

    // watchdog: cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int waited;
        error_count = 0;
        idle_cycles = 0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_RSVD;
        coord_x = 0; coord_y = 0; coord_z = 0;
        scale_x = 0; scale_y = 0; scale_z = 0;
        quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
        reset_transform();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_scenes();
        in_valid <= 1'b0;
        waited = 0;
        while (expected_boxes.size() != 0 && waited < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_boxes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
